// ----- rtl/core/srd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the signed restoring divider: controller
// states, the command group into the datapath and the status group back.
// ----------------------------------------------------------------------------
package srd_pkg;

   localparam int DATA_BITS     = 64;
   localparam int DEFAULT_WIDTH = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } srd_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } srd_cmd_type;

   typedef struct packed {
      logic div_zero;
   } srd_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/signed_restoring_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Signed two's-complement divider: magnitudes, restoring shift-subtract over
// WIDTH quotient bits, sign fix of quotient and remainder.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge loads the operands, ST_RUN retires one quotient
//   bit per cycle, ST_FIX applies the sign fix, and the result is strobed as
//   the controller returns to ST_IDLE; a zero divisor skips the loop.
// A new beat is not taken while busy; start is taken again in the cycle
//   the result is strobed. The receiver cannot stall.
// Reset: synchronous, active high; clears controller state and the strobe.
// ----------------------------------------------------------------------------
module signed_restoring_divider #(
   parameter int WIDTH = srd_pkg::DEFAULT_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [srd_pkg::DATA_BITS-1:0] req_dividend,
   input  wire logic [srd_pkg::DATA_BITS-1:0] req_divisor,
   output logic                               rsp_strobe,
   output logic [srd_pkg::DATA_BITS-1:0]      rsp_quotient,
   output logic [srd_pkg::DATA_BITS-1:0]      rsp_remainder,
   output logic                               rsp_divide_by_zero
);

   srd_pkg::srd_cmd_type    cmd;
   srd_pkg::srd_status_type status;

   srd_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   srd_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   // an accepted beat keeps the divider busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("divider not busy after accepting a beat");

   // the result is strobed as the controller returns to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobed on two cycles running");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_divide_by_zero) |->
         (rsp_quotient == '0) && (rsp_remainder == '0))
      else $error("divide by zero with non-zero result");

endmodule
`default_nettype wire

// ----- rtl/core/srd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srd_ctrl
// Controller of the divider: accepts a beat, counts the WIDTH shift-subtract
// steps, orders the sign fix and raises the result strobe.
// ----------------------------------------------------------------------------
module srd_ctrl #(
   parameter int WIDTH = srd_pkg::DEFAULT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_strobe,
   output srd_pkg::srd_cmd_type        cmd,
   input  wire srd_pkg::srd_status_type status
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   srd_pkg::srd_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srd_pkg::ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      strobe_in  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         srd_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = CW'(WIDTH - 1);
               state_in = srd_pkg::ST_RUN;
            end
         end
         srd_pkg::ST_RUN: begin
            // zero divisor: skip the iterations, the fix stage forces zeros
            if (status.div_zero) begin
               state_in = srd_pkg::ST_FIX;
            end else begin
               cmd.step = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = srd_pkg::ST_FIX;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         srd_pkg::ST_FIX: begin
            cmd.finish = 1'b1;
            strobe_in  = 1'b1;
            state_in   = srd_pkg::ST_IDLE;
         end
         default: begin
            state_in = srd_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != srd_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

// ----- rtl/core/srd_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srd_dpath
// Datapath of the divider: operand magnitudes, one restoring shift-subtract
// step per command, sign fix of quotient and remainder, result registers.
// ----------------------------------------------------------------------------
module srd_dpath #(
   parameter int WIDTH = srd_pkg::DEFAULT_WIDTH
) (
   input  wire logic                          clock,
   input  wire srd_pkg::srd_cmd_type          cmd,
   output srd_pkg::srd_status_type            status,
   input  wire logic [srd_pkg::DATA_BITS-1:0] req_dividend,
   input  wire logic [srd_pkg::DATA_BITS-1:0] req_divisor,
   output logic [srd_pkg::DATA_BITS-1:0]      rsp_quotient,
   output logic [srd_pkg::DATA_BITS-1:0]      rsp_remainder,
   output logic                               rsp_divide_by_zero
);

   logic [WIDTH-1:0] a_w, b_w, mag_a, mag_b;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic             differ_ff, differ_in;
   logic             zero_ff, zero_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] trial;
   logic             fits;
   logic signed [WIDTH-1:0] q_fix, r_fix;
   logic [srd_pkg::DATA_BITS-1:0] quotient_ff, quotient_in;
   logic [srd_pkg::DATA_BITS-1:0] remainder_ff, remainder_in;
   logic                          dbz_ff, dbz_in;

   // operand magnitudes, taken from the low WIDTH bits only
   assign a_w   = req_dividend[WIDTH-1:0];
   assign b_w   = req_divisor[WIDTH-1:0];
   assign mag_a = a_w[WIDTH-1] ? (~a_w + WIDTH'(1)) : a_w;
   assign mag_b = b_w[WIDTH-1] ? (~b_w + WIDTH'(1)) : b_w;

   // one restoring step: remainder stays below the divisor, so it fits WIDTH bits
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = ~trial[WIDTH+1];

   assign q_fix = differ_ff ? (~quo_ff + WIDTH'(1)) : quo_ff;
   assign r_fix = (differ_ff && (rem_ff != '0)) ? (div_ff - rem_ff) : rem_ff;

   always_comb begin
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      differ_in    = differ_ff;
      zero_in      = zero_ff;
      quotient_in  = quotient_ff;
      remainder_in = remainder_ff;
      dbz_in       = dbz_ff;
      if (cmd.load) begin
         rem_in    = '0;
         quo_in    = mag_a;
         div_in    = mag_b;
         differ_in = a_w[WIDTH-1] ^ b_w[WIDTH-1];
         zero_in   = (b_w == '0);
      end else if (cmd.step) begin
         rem_in = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
      end
      if (cmd.finish) begin
         if (zero_ff) begin
            quotient_in  = '0;
            remainder_in = '0;
         end else begin
            quotient_in  = srd_pkg::DATA_BITS'(q_fix);
            remainder_in = srd_pkg::DATA_BITS'(r_fix);
         end
         dbz_in = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_ff       <= div_in;
      differ_ff    <= differ_in;
      zero_ff      <= zero_in;
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
      dbz_ff       <= dbz_in;
   end

   assign status.div_zero    = zero_ff;
   assign rsp_quotient       = quotient_ff;
   assign rsp_remainder      = remainder_ff;
   assign rsp_divide_by_zero = dbz_ff;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for signed_restoring_divider. A driver offers operand
// pairs from a queue at the falling edge; a monitor takes each accepted beat
// at the rising edge, predicts quotient, remainder and divide-by-zero flag,
// and checks every strobed result against the oldest prediction. Directed
// corner pairs come first, then random phases with different sender gaps.
// ----------------------------------------------------------------------------
module tb;

   localparam int DATA_BITS = srd_pkg::DATA_BITS;
   localparam int WIDTH = srd_pkg::DEFAULT_WIDTH;
   localparam logic [DATA_BITS-1:0] MOST_NEG =
      {{(DATA_BITS - WIDTH + 1){1'b1}}, {(WIDTH - 1){1'b0}}};
   localparam logic [DATA_BITS-1:0] MOST_POS = ~MOST_NEG;
   localparam logic [DATA_BITS-1:0] MINUS_ONE = '1;

   typedef struct {
      logic [DATA_BITS-1:0] dividend;
      logic [DATA_BITS-1:0] divisor;
   } operands_type;

   typedef struct {
      logic [DATA_BITS-1:0] quotient;
      logic [DATA_BITS-1:0] remainder;
      logic                 divide_by_zero;
   } division_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [DATA_BITS-1:0] req_dividend = '0;
   logic [DATA_BITS-1:0] req_divisor = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [DATA_BITS-1:0] rsp_quotient;
   logic [DATA_BITS-1:0] rsp_remainder;
   logic                 rsp_divide_by_zero;

   operands_type pending_operands[$];
   division_type predicted_divisions[$];
   int           gap_pct = 0;
   int           mismatch_count = 0;
   bit           beat_taken = 1'b0;

   signed_restoring_divider #(.WIDTH(WIDTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_strobe         (rsp_strobe),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Truncating signed division at WIDTH bits; remainder per the block's rule.
   function automatic division_type divide_signed(logic [DATA_BITS-1:0] num,
                                                  logic [DATA_BITS-1:0] den);
      logic [WIDTH-1:0] mag_num;
      logic [WIDTH-1:0] mag_den;
      logic [WIDTH-1:0] quo;
      logic [WIDTH-1:0] rem;
      logic             flip;
      division_type     res;
      mag_num = num[WIDTH-1:0];
      mag_den = den[WIDTH-1:0];
      res.quotient = '0;
      res.remainder = '0;
      res.divide_by_zero = 1'b0;
      if (mag_den == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      flip = mag_num[WIDTH-1] ^ mag_den[WIDTH-1];
      if (mag_num[WIDTH-1]) mag_num = -mag_num;
      if (mag_den[WIDTH-1]) mag_den = -mag_den;
      quo = mag_num / mag_den;
      rem = mag_num % mag_den;
      if (flip) begin
         quo = -quo;
         if (rem != '0) rem = mag_den - rem;
      end
      res.quotient = DATA_BITS'($signed(quo));
      res.remainder = DATA_BITS'($signed(rem));
      return res;
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_operand();
      logic [DATA_BITS-1:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return MINUS_ONE;
         3: return DATA_BITS'($urandom_range(0, 15));
         4: return -DATA_BITS'($urandom_range(1, 15));
         8: return wide >> $urandom_range(0, DATA_BITS - 1);
         9: return -(wide >> $urandom_range(0, DATA_BITS - 1));
         default: return wide;
      endcase
   endfunction

   task automatic add_pair(logic [DATA_BITS-1:0] num, logic [DATA_BITS-1:0] den);
      operands_type op;
      op.dividend = num;
      op.divisor = den;
      pending_operands.insert(pending_operands.size(), op);
   endtask

   task automatic add_random(int count);
      logic [DATA_BITS-1:0] den;
      repeat (count) begin
         den = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
         add_pair(pick_operand(), den);
      end
   endtask

   // Hold until every queued beat is taken and every result has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_operands.size() != 0 || start || predicted_divisions.size() != 0);
   endtask

   // Driver: offer a beat, hold it until taken, idle at random between beats.
   always @(negedge clock) begin
      operands_type op;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_operands.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            op = pending_operands.pop_front();
            start <= 1'b1;
            req_dividend <= op.dividend;
            req_divisor <= op.divisor;
         end else begin
            start <= 1'b0;
            req_dividend <= {$urandom, $urandom};
            req_divisor <= {$urandom, $urandom};
         end
      end
   end

   // Monitor: predict on each accepted beat, check each strobed result.
   always @(posedge clock) begin
      division_type want;
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         beat_taken = start && !busy;
         if (beat_taken)
            predicted_divisions.insert(predicted_divisions.size(),
                                       divide_signed(req_dividend, req_divisor));
         if (rsp_strobe) begin
            if (predicted_divisions.size() == 0) begin
               $display("%0t: unexpected result q=%h r=%h dz=%b", $realtime,
                        rsp_quotient, rsp_remainder, rsp_divide_by_zero);
               mismatch_count++;
            end else begin
               want = predicted_divisions.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  $display("%0t: quotient expected %h actual %h", $realtime,
                           want.quotient, rsp_quotient);
                  mismatch_count++;
               end
               if (rsp_remainder !== want.remainder) begin
                  $display("%0t: remainder expected %h actual %h", $realtime,
                           want.remainder, rsp_remainder);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero !== want.divide_by_zero) begin
                  $display("%0t: divide_by_zero expected %b actual %b", $realtime,
                           want.divide_by_zero, rsp_divide_by_zero);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner pairs: signs, zero divisor, most negative, exact division.
      gap_pct = 0;
      add_pair('0, 64'd1);
      add_pair(64'd1, 64'd1);
      add_pair(MINUS_ONE, 64'd1);
      add_pair(64'd7, 64'd2);
      add_pair(-64'd7, 64'd2);
      add_pair(64'd7, -64'd2);
      add_pair(-64'd7, -64'd2);
      add_pair(64'd6, -64'd3);
      add_pair(-64'd6, 64'd3);
      add_pair(64'd5, 64'd7);
      add_pair(-64'd5, 64'd7);
      add_pair(MOST_NEG, MINUS_ONE);
      add_pair(MOST_NEG, 64'd1);
      add_pair(MOST_NEG, MOST_NEG);
      add_pair(MOST_POS, MOST_NEG);
      add_pair(MOST_POS, MINUS_ONE);
      add_pair(MOST_NEG, MOST_POS);
      add_pair(MOST_POS, MOST_POS);
      add_pair(64'd1, MOST_NEG);
      add_pair(MOST_NEG, 64'd3);
      add_pair('0, '0);
      add_pair(MOST_NEG, '0);
      add_pair(MINUS_ONE, '0);
      add_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      wait_drained();

      add_random(120);
      wait_drained();

      gap_pct = 88;
      add_random(70);
      wait_drained();

      // Long gaps so offers also land after the block has gone idle.
      gap_pct = 99;
      add_random(30);
      wait_drained();

      gap_pct = 13;
      add_random(120);
      wait_drained();

      gap_pct = 0;
      add_random(60);
      wait_drained();

      repeat (WIDTH + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("signed_restoring_divider regression: pass");
      else
         $display("signed_restoring_divider regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("signed_restoring_divider regression: fail");
      $finish;
   end

endmodule

// ----- signed_restoring_divider.f -----
rtl/core/srd_pkg.sv
rtl/core/srd_ctrl.sv
rtl/core/srd_dpath.sv
rtl/core/signed_restoring_divider.sv
tb/sv/tb.sv
